@@ hw/rtl/bsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  // Default geometry of the bitmap.
  localparam int MAX_WORDS_DEF = 64;
  localparam int WORD_BITS_DEF = 64;

  // Fixed field widths of the command and response words.
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 12;
  localparam int SPAN_W  = 13;
  localparam int CFG_W   = 7;
  localparam int FREE_W  = 13;
  localparam int START_W = 12;

  localparam logic [CFG_W-1:0]  WORDS_RESET = 7'd64;
  localparam logic [FREE_W-1:0] FREE_SAT    = 13'h1FFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 3'd0,
    CMD_CLEAR = 3'd1,
    CMD_READ  = 3'd2,
    CMD_COUNT = 3'd3,
    CMD_ALLOC = 3'd4,
    CMD_FIND  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_RANGE    = 2'd1,
    STS_NO_RUN   = 2'd2,
    STS_ZERO_RUN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_MARK_WR,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/bitmap_span_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A command is accepted only in the idle state, and the next one stalls until its response
//   word is loaded: the scan walks the active words through the single memory read port,
//   one word per cycle, then an allocation marks its run (a fully covered word by one write,
//   a partly covered word by a read and a write), and the finish step loads the response.
//   Reset (rst, synchronous) clears control state and starts a clearing pass over every
//   memory word; commands stall during it.
module bitmap_span_allocator #(
  parameter int MAX_WORDS = bsa_pkg::MAX_WORDS_DEF,
  parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Command channel.
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [bsa_pkg::CMD_W-1:0]     cmd,
  input  logic [bsa_pkg::IDX_W-1:0]     bit_index,
  input  logic [bsa_pkg::SPAN_W-1:0]    run_length,
  // Response channel.
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          bit_value,
  output logic [bsa_pkg::START_W-1:0]   run_start,
  output logic [bsa_pkg::FREE_W-1:0]    free_count,
  output logic [1:0]                    status,
  // Configuration write channel for words_in_use.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsa_pkg::CFG_W-1:0]     words_in_use
);
  import bsa_pkg::*;

  localparam int AWD   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int NWW   = $clog2(MAX_WORDS + 1);
  localparam int TOTAL = MAX_WORDS * WORD_BITS;
  localparam int PW    = $clog2(TOTAL + 1);
  localparam int GW    = ((PW > SPAN_W) ? PW : SPAN_W) + 1;
  localparam int OW    = $clog2(WORD_BITS);
  localparam int CNTW  = $clog2(WORD_BITS + 1);
  localparam int CW    = SPAN_W + 1;

  // The whole bitmap lives in one memory with a registered read port. Every
  // command walks the active words once: the walk counts free bits, performs
  // the single-bit operations on the word that holds the index, and looks for
  // the first run of free bits. A run command that allocates then walks back
  // from the word where the run ends, marking its bits as used.

  state_t state, state_next;

  logic [CFG_W-1:0]   words_reg;
  logic [NWW-1:0]     nwords;

  cmd_t               cmd_r;
  logic [IDX_W-1:0]   idx_r;
  logic [SPAN_W-1:0]  span_r;

  logic [WORD_BITS-1:0] mem [MAX_WORDS];
  logic [WORD_BITS-1:0] rd_data;

  logic               accept;
  logic               bit_cmd;
  logic               write_cmd;
  logic               alloc_cmd;
  logic               search_en;

  // Scan issue and pipeline.
  logic [NWW-1:0]     scan_cnt;
  logic [PW-1:0]      scan_base;
  logic               issue;
  logic               in_word;
  logic [OW-1:0]      idx_off;
  logic               scan_done;

  logic               p1_valid;
  logic [AWD-1:0]     p1_addr;
  logic [PW-1:0]      p1_base;
  logic               p1_tgt;
  logic [WORD_BITS-1:0] p1_mask;
  logic [WORD_BITS-1:0] word_mod;
  logic               wr_scan;

  logic [AWD-1:0]     p2_addr;
  logic [PW-1:0]      p2_base;
  logic               p2_tgt;
  logic               p2_bit;

  logic               ev_valid;
  logic [CNTW-1:0]    ev_pop;
  logic [CNTW-1:0]    ev_trail;
  logic [CNTW-1:0]    ev_lead;
  logic               ev_all_free;
  logic               ev_inner;
  logic [OW-1:0]      ev_pos;

  // Scan results.
  logic [PW-1:0]      free_acc;
  logic [CW-1:0]      carry;
  logic [CW-1:0]      carry_next;
  logic [CW-1:0]      pre_end;
  logic               pre_hit;
  logic               in_hit;
  logic               hit;
  logic [AWD-1:0]     hit_addr;
  logic [OW-1:0]      hit_end;
  logic [PW-1:0]      hit_start;
  logic               tgt_found;
  logic               bit_res;

  // Marking walk.
  logic [AWD-1:0]     mk_addr;
  logic [OW-1:0]      mk_hi;
  logic [SPAN_W-1:0]  mk_rem;
  logic [CNTW-1:0]    mk_hi_p1;
  logic [CNTW-1:0]    mk_n;
  logic [OW-1:0]      mk_lo;
  logic [WORD_BITS-1:0] mk_mask;
  logic               mk_full;
  logic               mk_last;
  logic               mk_adv;

  logic [AWD-1:0]     clr_addr;

  // Memory port controls.
  logic               re;
  logic [AWD-1:0]     raddr;
  logic               we;
  logic [AWD-1:0]     waddr;
  logic [WORD_BITS-1:0] wdata;

  logic               load_rsp;
  logic [GW-1:0]      fin_free;
  status_t            fin_status;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;

  // A register value above the memory size acts as the memory size.
  assign nwords = (int'(words_reg) > MAX_WORDS) ? NWW'(MAX_WORDS) : NWW'(words_reg);

  always_comb begin
    bit_cmd   = 1'b0;
    write_cmd = 1'b0;
    alloc_cmd = 1'b0;
    search_en = 1'b0;
    case (cmd_r) inside
      CMD_SET, CMD_CLEAR: begin
        bit_cmd   = 1'b1;
        write_cmd = 1'b1;
      end
      CMD_READ: begin
        bit_cmd = 1'b1;
      end
      CMD_ALLOC: begin
        alloc_cmd = 1'b1;
        search_en = (span_r != '0);
      end
      CMD_FIND: begin
        search_en = (span_r != '0);
      end
      default: begin
      end
    endcase
  end

  // Word that holds the addressed bit, checked as each read is issued.
  assign in_word = (GW'(idx_r) >= GW'(scan_base)) &&
                   (GW'(idx_r) < GW'(scan_base) + GW'(WORD_BITS));
  assign idx_off = OW'(GW'(idx_r) - GW'(scan_base));
  assign issue   = (state == S_SCAN) && (scan_cnt != nwords);
  assign scan_done = (scan_cnt == nwords) && !p1_valid && !ev_valid;

  // Single-bit update of the target word as it leaves the memory.
  always_comb begin
    word_mod = rd_data;
    if (p1_tgt && (cmd_r == CMD_SET)) begin
      word_mod = rd_data | p1_mask;
    end else if (p1_tgt && (cmd_r == CMD_CLEAR)) begin
      word_mod = rd_data & ~p1_mask;
    end
  end
  assign wr_scan = p1_valid && p1_tgt && write_cmd;

  bsa_word_eval #(
    .WORD_BITS (WORD_BITS)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .en        (p1_valid),
    .word      (word_mod),
    .span      (span_r),
    .valid     (ev_valid),
    .pop       (ev_pop),
    .trail     (ev_trail),
    .lead      (ev_lead),
    .all_free  (ev_all_free),
    .inner     (ev_inner),
    .inner_pos (ev_pos)
  );

  // Run search across words. carry is the free streak that reaches the
  // bottom of the current word. A run that started below this word ends at
  // pre_end if the word's low free bits reach that far; that hit always comes
  // before any run lying wholly inside the word.
  assign pre_end    = CW'(span_r) - carry - CW'(1);
  assign pre_hit    = CW'(ev_trail) > pre_end;
  assign in_hit     = (GW'(span_r) <= GW'(WORD_BITS)) && ev_inner;
  assign carry_next = ev_all_free ? (carry + CW'(WORD_BITS)) : CW'(ev_lead);

  // Marking covers bits mk_lo..mk_hi of the current word, walking downward.
  assign mk_hi_p1 = CNTW'(mk_hi) + CNTW'(1);
  assign mk_n     = (SPAN_W'(mk_hi_p1) > mk_rem) ? CNTW'(mk_rem) : mk_hi_p1;
  assign mk_lo    = OW'(mk_hi_p1 - mk_n);
  assign mk_mask  = ({WORD_BITS{1'b1}} >> (OW'(WORD_BITS - 1) - mk_hi)) &
                    ({WORD_BITS{1'b1}} << mk_lo);
  assign mk_full  = (mk_n == CNTW'(WORD_BITS));
  assign mk_last  = (mk_rem == SPAN_W'(mk_n));
  assign mk_adv   = ((state == S_MARK) && mk_full) || (state == S_MARK_WR);

  always_comb begin
    state_next = state;
    re         = issue;
    raddr      = scan_cnt[AWD-1:0];
    we         = wr_scan;
    waddr      = p1_addr;
    wdata      = word_mod;
    load_rsp   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == AWD'(MAX_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = (alloc_cmd && hit) ? S_MARK : S_FINISH;
        end
      end
      S_MARK: begin
        if (mk_full) begin
          we    = 1'b1;
          waddr = mk_addr;
          wdata = '1;
          if (mk_last) begin
            state_next = S_FINISH;
          end
        end else begin
          re         = 1'b1;
          raddr      = mk_addr;
          state_next = S_MARK_WR;
        end
      end
      S_MARK_WR: begin
        we         = 1'b1;
        waddr      = mk_addr;
        wdata      = rd_data | mk_mask;
        state_next = mk_last ? S_FINISH : S_MARK;
      end
      S_FINISH: begin
        load_rsp = !rsp_valid || !rsp_stall;
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_reg <= WORDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      words_reg <= words_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + AWD'(1);
    end
  end

  // Bitmap memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(cmd);
      idx_r  <= bit_index;
      span_r <= run_length;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_cnt  <= '0;
      scan_base <= '0;
    end else if (issue) begin
      scan_cnt  <= scan_cnt + NWW'(1);
      scan_base <= scan_base + PW'(WORD_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_addr <= scan_cnt[AWD-1:0];
      p1_base <= scan_base;
      p1_tgt  <= bit_cmd && in_word;
      p1_mask <= {{(WORD_BITS-1){1'b0}}, 1'b1} << idx_off;
    end
    if (p1_valid) begin
      p2_addr <= p1_addr;
      p2_base <= p1_base;
      p2_tgt  <= p1_tgt;
      p2_bit  <= |(rd_data & p1_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit       <= 1'b0;
      tgt_found <= 1'b0;
    end else if (accept) begin
      hit       <= 1'b0;
      tgt_found <= 1'b0;
    end else if (ev_valid) begin
      if (p2_tgt) begin
        tgt_found <= 1'b1;
      end
      if (search_en && !hit && (pre_hit || in_hit)) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      free_acc <= '0;
      carry    <= '0;
      bit_res  <= 1'b0;
    end else if (ev_valid) begin
      free_acc <= free_acc + PW'(ev_pop);
      if (p2_tgt) begin
        bit_res <= p2_bit;
      end
      if (search_en && !hit) begin
        if (pre_hit) begin
          hit_addr  <= p2_addr;
          hit_end   <= OW'(pre_end);
          hit_start <= PW'(GW'(p2_base) - GW'(carry));
        end else if (in_hit) begin
          hit_addr  <= p2_addr;
          hit_end   <= ev_pos;
          hit_start <= PW'(GW'(p2_base) + GW'(ev_pos) + GW'(1) - GW'(span_r));
        end else begin
          carry <= carry_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && (state_next == S_MARK)) begin
      mk_addr <= hit_addr;
      mk_hi   <= hit_end;
      mk_rem  <= span_r;
    end else if (mk_adv) begin
      mk_addr <= mk_addr - AWD'(1);
      mk_hi   <= OW'(WORD_BITS - 1);
      mk_rem  <= mk_rem - SPAN_W'(mk_n);
    end
  end

  // The allocated run was all free and inside the active words, so the
  // count after marking is the scanned count less the run length.
  assign fin_free = (alloc_cmd && hit) ? (GW'(free_acc) - GW'(span_r)) : GW'(free_acc);

  always_comb begin
    fin_status = STS_OK;
    case (cmd_r) inside
      CMD_SET, CMD_CLEAR, CMD_READ: begin
        fin_status = tgt_found ? STS_OK : STS_RANGE;
      end
      CMD_ALLOC, CMD_FIND: begin
        if (span_r == '0) begin
          fin_status = STS_ZERO_RUN;
        end else if (!hit) begin
          fin_status = STS_NO_RUN;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      bit_value  <= (cmd_r == CMD_READ) && tgt_found && bit_res;
      run_start  <= (search_en && hit) ? START_W'(hit_start) : '0;
      free_count <= (fin_free > GW'(FREE_SAT)) ? FREE_SAT : FREE_W'(fin_free);
      status     <= fin_status;
    end
  end

`ifndef SYNTH
  // Word summaries only flow while a scan is running.
  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (state == S_SCAN))
    else $error("word summary outside of a scan");

  // Until a run is found, the carried free streak stays shorter than the run.
  a_carry_short: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && search_en && !hit) |-> (carry < CW'(span_r)))
    else $error("carried free streak reached the run length without a hit");

  // Marking happens only for an allocation that found its run.
  a_mark_after_hit: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MARK) || (state == S_MARK_WR)) |-> (hit && alloc_cmd))
    else $error("marking without a found run");

  // A new response word appears only out of the finish step.
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FINISH))
    else $error("response raised outside the finish step");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/bsa_word_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Registered per-word summary used by the scan: free count, free runs at both
// ends, and the lowest end position of a run of span free bits inside the word.
module bsa_word_eval #(
  parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic [WORD_BITS-1:0]               word,
  input  logic [bsa_pkg::SPAN_W-1:0]         span,
  output logic                               valid,
  output logic [$clog2(WORD_BITS+1)-1:0]     pop,
  output logic [$clog2(WORD_BITS+1)-1:0]     trail,
  output logic [$clog2(WORD_BITS+1)-1:0]     lead,
  output logic                               all_free,
  output logic                               inner,
  output logic [$clog2(WORD_BITS)-1:0]       inner_pos
);
  import bsa_pkg::*;

  localparam int OW   = $clog2(WORD_BITS);
  localparam int CNTW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] freev;
  logic [WORD_BITS-1:0] runs;
  logic [WORD_BITS-1:0] dbl;
  logic [CNTW-1:0]      pop_c;
  logic [CNTW-1:0]      trail_c;
  logic [CNTW-1:0]      lead_c;
  logic [OW-1:0]        pos_c;

  // A bit of dbl at step k marks 2**k free bits ending there; runs gathers
  // the power-of-two pieces that make up span.
  always_comb begin
    freev = ~word;
    runs  = '1;
    dbl   = freev;
    for (int k = 0; k < CNTW; k++) begin
      if (span[k]) begin
        runs = dbl & (runs << (1 << k));
      end
      dbl = dbl & (dbl << (1 << k));
    end

    pos_c = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (runs[i]) begin
        pos_c = OW'(i);
      end
    end

    trail_c = CNTW'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        trail_c = CNTW'(i);
      end
    end

    lead_c = CNTW'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (word[i]) begin
        lead_c = CNTW'(WORD_BITS - 1 - i);
      end
    end

    pop_c = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pop_c = pop_c + CNTW'(freev[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= en;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pop       <= pop_c;
      trail     <= trail_c;
      lead      <= lead_c;
      all_free  <= (word == '0);
      inner     <= |runs;
      inner_pos <= pos_c;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_bitmap_span_allocator.sv @@
`timescale 1ns / 1ps

module tb_bitmap_span_allocator;
  import bsa_pkg::*;

  localparam int UNIT_BITS   = WORD_BITS_DEF;
  localparam int WORD_SLOTS  = MAX_WORDS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 250;
  localparam int IDLE_PCT    = 32;
  localparam int SCRIPT_ROWS = 26;

  // Codes 6 and 7 are not decoded by the allocator; they must leave the map alone.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic               bitv;
    logic [START_W-1:0] start;
    logic [FREE_W-1:0]  free;
    status_t            st;
  } alloc_reply_t;

  // One row of the directed script: optional words_in_use write, the command, and a
  // hand-written reply where it is obvious (otherwise the reply comes from the predictor).
  typedef struct packed {
    logic               do_cfg;
    logic [CFG_W-1:0]   cfg_val;
    logic [CMD_W-1:0]   op;
    logic [IDX_W-1:0]   idx;
    logic [SPAN_W-1:0]  span;
    logic               lit;
    alloc_reply_t       reply;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cmd_valid;
  logic                cmd_stall;
  logic [CMD_W-1:0]    cmd;
  logic [IDX_W-1:0]    bit_index;
  logic [SPAN_W-1:0]   run_length;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic                bit_value;
  logic [START_W-1:0]  run_start;
  logic [FREE_W-1:0]   free_count;
  logic [1:0]          status;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    words_in_use;

  // Predictor state: our own copy of the bitmap and of the word-count register.
  logic [UNIT_BITS-1:0] unit_map [WORD_SLOTS];
  logic [CFG_W-1:0]     words_managed;
  alloc_reply_t         replies_due [$];
  int                   mismatches = 0;
  int unsigned          cycle_count = 0;
  bit                   quiet = 1'b0;

  script_row_t script [SCRIPT_ROWS] = '{
    // Fresh map, 64 words: every unit free.
    '{1'b0, 7'd0, CMD_READ,  12'd0,    13'd0,    1'b1, '{1'b0, 12'd0,   13'd4096, STS_OK}},
    '{1'b0, 7'd0, CMD_READ,  12'd4095, 13'd8191, 1'b1, '{1'b0, 12'd0,   13'd4096, STS_OK}},
    '{1'b0, 7'd0, CMD_FIND,  12'd0,    13'd4096, 1'b1, '{1'b0, 12'd0,   13'd4096, STS_OK}},
    '{1'b0, 7'd0, CMD_FIND,  12'd0,    13'd4097, 1'b1, '{1'b0, 12'd0,   13'd4096, STS_NO_RUN}},
    '{1'b0, 7'd0, CMD_ALLOC, 12'd4095, 13'd8191, 1'b1, '{1'b0, 12'd0,   13'd4096, STS_NO_RUN}},
    '{1'b0, 7'd0, CMD_ALLOC, 12'd0,    13'd0,    1'b1, '{1'b0, 12'd0,   13'd4096, STS_ZERO_RUN}},
    '{1'b0, 7'd0, CMD_SET,   12'd4095, 13'd0,    1'b1, '{1'b0, 12'd0,   13'd4095, STS_OK}},
    '{1'b0, 7'd0, CMD_SET,   12'd0,    13'd0,    1'b1, '{1'b0, 12'd0,   13'd4094, STS_OK}},
    '{1'b0, 7'd0, CMD_READ,  12'd4095, 13'd0,    1'b1, '{1'b1, 12'd0,   13'd4094, STS_OK}},
    '{1'b0, 7'd0, CMD_CLEAR, 12'd4095, 13'd0,    1'b1, '{1'b0, 12'd0,   13'd4095, STS_OK}},
    '{1'b0, 7'd0, CMD_ALLOC, 12'd0,    13'd1,    1'b1, '{1'b0, 12'd1,   13'd4094, STS_OK}},
    '{1'b0, 7'd0, CMD_ALLOC, 12'd0,    13'd100,  1'b1, '{1'b0, 12'd2,   13'd3994, STS_OK}},
    // This run straddles the boundary between words 1 and 2.
    '{1'b0, 7'd0, CMD_ALLOC, 12'd0,    13'd62,   1'b1, '{1'b0, 12'd102, 13'd3932, STS_OK}},
    // A lone used unit inside a free stretch must restart the streak.
    '{1'b0, 7'd0, CMD_SET,   12'd200,  13'd0,    1'b0, '0},
    '{1'b0, 7'd0, CMD_FIND,  12'd0,    13'd100,  1'b0, '0},
    '{1'b0, 7'd0, CMD_SPARE_LO, 12'd2730, 13'd5461, 1'b0, '0},
    '{1'b0, 7'd0, CMD_SPARE_HI, 12'd1365, 13'd2730, 1'b0, '0},
    '{1'b0, 7'd0, CMD_CLEAR, 12'd0,    13'd0,    1'b0, '0},
    '{1'b0, 7'd0, CMD_ALLOC, 12'd0,    13'd4096, 1'b1, '{1'b0, 12'd0,   13'd3932, STS_NO_RUN}},
    // One word: index 64 is past the end, bit 0 is the only free unit.
    '{1'b1, 7'd1, CMD_SET,   12'd64,   13'd0,    1'b1, '{1'b0, 12'd0,   13'd1,    STS_RANGE}},
    '{1'b0, 7'd0, CMD_ALLOC, 12'd0,    13'd2,    1'b1, '{1'b0, 12'd0,   13'd1,    STS_NO_RUN}},
    '{1'b0, 7'd0, CMD_ALLOC, 12'd0,    13'd1,    1'b1, '{1'b0, 12'd0,   13'd0,    STS_OK}},
    // Empty map: nothing is in range and nothing is free.
    '{1'b1, 7'd0, CMD_COUNT, 12'd0,    13'd0,    1'b1, '{1'b0, 12'd0,   13'd0,    STS_OK}},
    '{1'b0, 7'd0, CMD_SET,   12'd0,    13'd0,    1'b1, '{1'b0, 12'd0,   13'd0,    STS_RANGE}},
    '{1'b0, 7'd0, CMD_FIND,  12'd0,    13'd1,    1'b1, '{1'b0, 12'd0,   13'd0,    STS_NO_RUN}},
    // An oversized register value behaves as the full 64 words.
    '{1'b1, 7'd127, CMD_READ, 12'd4095, 13'd0,   1'b0, '0}
  };

  bitmap_span_allocator uut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .bit_index    (bit_index),
    .run_length   (run_length),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .bit_value    (bit_value),
    .run_start    (run_start),
    .free_count   (free_count),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .words_in_use (words_in_use)
  );

  always #4 clk = ~clk;

  function automatic int live_words();
    return (words_managed > WORD_SLOTS) ? WORD_SLOTS : int'(words_managed);
  endfunction

  // Applies one command to the local map and returns the reply the allocator owes for it.
  function automatic alloc_reply_t apply_command(input logic [CMD_W-1:0] op,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic [SPAN_W-1:0] span);
    alloc_reply_t r;
    int nbits;
    int streak;
    int p;
    int run_at;
    int free_bits;
    bit hit;
    r.bitv  = 1'b0;
    r.start = '0;
    r.free  = '0;
    r.st    = STS_OK;
    nbits = live_words() * UNIT_BITS;
    case (op)
      CMD_SET, CMD_CLEAR, CMD_READ: begin
        if (idx >= nbits) begin
          r.st = STS_RANGE;
        end else if (op == CMD_SET) begin
          unit_map[idx / UNIT_BITS][idx % UNIT_BITS] = 1'b1;
        end else if (op == CMD_CLEAR) begin
          unit_map[idx / UNIT_BITS][idx % UNIT_BITS] = 1'b0;
        end else begin
          r.bitv = unit_map[idx / UNIT_BITS][idx % UNIT_BITS];
        end
      end
      CMD_ALLOC, CMD_FIND: begin
        if (span == 0) begin
          r.st = STS_ZERO_RUN;
        end else begin
          // First fit: walk every active unit, a used one zeroes the streak.
          streak = 0;
          run_at = 0;
          hit = 1'b0;
          for (p = 0; p < nbits && !hit; p++) begin
            if (unit_map[p / UNIT_BITS][p % UNIT_BITS]) begin
              streak = 0;
            end else begin
              streak++;
              if (streak == span) begin
                run_at = p + 1 - int'(span);
                hit = 1'b1;
              end
            end
          end
          if (!hit) begin
            r.st = STS_NO_RUN;
          end else begin
            r.start = run_at[START_W-1:0];
            if (op == CMD_ALLOC) begin
              for (p = run_at; p < run_at + int'(span); p++)
                unit_map[p / UNIT_BITS][p % UNIT_BITS] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    free_bits = 0;
    for (p = 0; p < live_words(); p++)
      free_bits += UNIT_BITS - $countones(unit_map[p]);
    r.free = free_bits[FREE_W-1:0];
    return r;
  endfunction

  // Offers one command word, holds it until accepted, then records the reply it owes.
  // Entered and left at a falling edge; valid stays high so back-to-back words need no gap.
  task automatic send_word(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [SPAN_W-1:0] span, input logic lit,
                           input alloc_reply_t lit_reply);
    alloc_reply_t r;
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        cmd_valid = 1'b0;
        @(negedge clk);
      end
    end
    cmd        = op;
    bit_index  = idx;
    run_length = span;
    cmd_valid  = 1'b1;
    do @(posedge clk); while (cmd_stall);
    r = apply_command(op, idx, span);
    replies_due.push_back(lit ? lit_reply : r);
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_valid = 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  // The register only moves while the allocator has nothing in flight.
  task automatic write_words(input logic [CFG_W-1:0] value);
    drain();
    words_in_use = value;
    cfg_valid    = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    words_managed = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(input int nbits);
    return (nbits == 0) ? IDX_W'($urandom_range(4095)) : IDX_W'($urandom_range(nbits - 1));
  endfunction

  // Mostly short runs so allocations keep succeeding; now and then one near or past the map size.
  function automatic logic [SPAN_W-1:0] pick_span(input int nbits);
    int r;
    r = $urandom_range(99);
    if (r < 60) return SPAN_W'($urandom_range(16, 1));
    if (r < 85) return SPAN_W'($urandom_range(128, 17));
    if (r < 95) return SPAN_W'($urandom_range(nbits + 8, 1));
    return SPAN_W'($urandom_range(8191, 1));
  endfunction

  // Emits one random command, or a short stretch of frees, and reports how many words went out.
  task automatic random_burst(output int made);
    int nbits;
    int r;
    int k;
    int j;
    logic [IDX_W-1:0] base;
    nbits = live_words() * UNIT_BITS;
    r = $urandom_range(99);
    made = 1;
    if (r < 28) begin
      send_word(CMD_ALLOC, IDX_W'($urandom), pick_span(nbits), 1'b0, '0);
    end else if (r < 40) begin
      send_word(CMD_FIND, IDX_W'($urandom), pick_span(nbits), 1'b0, '0);
    end else if (r < 62) begin
      // Free a few neighbors to punch holes of varied width into allocated runs.
      k = $urandom_range(6, 1);
      base = pick_index(nbits);
      for (j = 0; j < k; j++)
        send_word(CMD_CLEAR, base + IDX_W'(j), SPAN_W'($urandom), 1'b0, '0);
      made = k;
    end else if (r < 72) begin
      send_word(CMD_SET, pick_index(nbits), SPAN_W'($urandom), 1'b0, '0);
    end else if (r < 84) begin
      send_word(CMD_READ, pick_index(nbits), SPAN_W'($urandom), 1'b0, '0);
    end else if (r < 90) begin
      send_word(CMD_COUNT, IDX_W'($urandom), SPAN_W'($urandom), 1'b0, '0);
    end else begin
      case ($urandom_range(3))
        0: send_word(CMD_W'($urandom_range(2)), IDX_W'($urandom), SPAN_W'($urandom),
                     1'b0, '0);
        1: send_word($urandom_range(1) ? CMD_ALLOC : CMD_FIND, IDX_W'($urandom), '0,
                     1'b0, '0);
        2: send_word($urandom_range(1) ? CMD_ALLOC : CMD_FIND, IDX_W'($urandom),
                     SPAN_W'($urandom), 1'b0, '0);
        default: send_word($urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO, IDX_W'($urandom),
                           SPAN_W'($urandom), 1'b0, '0);
      endcase
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // The receiver stalls at random, except during the quiet stretch.
  always @(negedge clk) begin
    rsp_stall = !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : reply_check
    alloc_reply_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: reply word with none expected, actual status %0d start %0d free %0d",
                 $time, status, run_start, free_count);
      end else begin
        want = replies_due.pop_front();
        check_field("bit_value", want.bitv, bit_value);
        check_field("run_start", want.start, run_start);
        check_field("free_count", want.free, free_count);
        check_field("status", want.st, status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               replies_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_words [9] = '{64, 1, 2, 64, -1, 127, 0, -1, 64};
    int phase_len [9]   = '{150, 80, 80, 120, 80, 80, 15, 50, 45};
    int i;
    int ph;
    int sent;
    int made;
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd          = CMD_SET;
    bit_index    = '0;
    run_length   = '0;
    cfg_valid    = 1'b0;
    words_in_use = WORDS_RESET;
    words_managed = WORDS_RESET;
    for (i = 0; i < WORD_SLOTS; i++) unit_map[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed script: corners of each field, every command, each error status.
    for (i = 0; i < SCRIPT_ROWS; i++) begin
      if (script[i].do_cfg) write_words(script[i].cfg_val);
      send_word(script[i].op, script[i].idx, script[i].span, script[i].lit, script[i].reply);
    end

    // Random phases, each under its own map size; a negative entry picks one at random.
    for (ph = 0; ph < 9; ph++) begin
      write_words(phase_words[ph] < 0 ? CFG_W'($urandom_range(WORD_SLOTS, 1))
                                      : CFG_W'(phase_words[ph]));
      quiet = (ph == 3);
      sent = 0;
      while (sent < phase_len[ph]) begin
        if (quiet && sent >= 100) quiet = 1'b0;
        random_burst(made);
        sent += made;
      end
      quiet = 1'b0;
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
